/* rtl/core/css_pkg.sv */
// shared widths, constants and the job word for the cosine similarity stream
`timescale 1ns / 1ps
`default_nettype none

package css_pkg;

	// element and result widths
	localparam int ELEM_W = 16;
	localparam int PRODUCT_W = 2 * ELEM_W;
	localparam int SIM_W = 16;

	// accumulator widths, Q9.28 dot product and UQ9.28 sums of squares
	localparam int DOT_W = 38;
	localparam int SQ_W = 37;

	// back end datapath widths
	localparam int MAG_W = DOT_W;
	localparam int PROD_W = 2 * SQ_W;
	localparam int MAGSQ_W = 2 * MAG_W;
	localparam int QUO_W = 32;
	localparam int REM_W = MAGSQ_W + 30;
	localparam int ROOT_W = QUO_W / 2;
	localparam int SREM_W = ROOT_W + 3;

	// step counts of the iterative units
	localparam int MUL_STEPS = MAG_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int CNT_W = 6;

	// accumulator limits
	localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};
	localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
	localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};

	// one in Q1.14
	localparam logic signed [SIM_W-1:0] ONE_Q14 = 16'sh4000;

	// finished sums of one vector pair, handed from front to back
	typedef struct packed {
		logic signed [DOT_W-1:0] dot;
		logic [SQ_W-1:0] sa;
		logic [SQ_W-1:0] sb;
		logic ovf;
	} job_t;

endpackage

`default_nettype wire

/* rtl/core/css_front.sv */
// front end: element products and saturating accumulators, one pair a cycle but for a held final pair
`timescale 1ns / 1ps
`default_nettype none

module css_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic signed [css_pkg::ELEM_W-1:0] elem_a,
	input wire logic signed [css_pkg::ELEM_W-1:0] elem_b,
	input wire logic last,
	input wire logic push,
	output logic full,
	output css_pkg::job_t job,
	output logic job_push,
	input wire logic q_full
);

	logic valid_s1;
	logic last_s1;
	logic signed [css_pkg::PRODUCT_W-1:0] ab_s1;
	logic [css_pkg::PRODUCT_W-1:0] aa_s1;
	logic [css_pkg::PRODUCT_W-1:0] bb_s1;

	logic signed [css_pkg::DOT_W-1:0] dot_q;
	logic [css_pkg::SQ_W-1:0] sa_q;
	logic [css_pkg::SQ_W-1:0] sb_q;
	logic ovf_q;

	logic advance;
	logic signed [css_pkg::PRODUCT_W-1:0] ab_full;
	logic signed [css_pkg::PRODUCT_W-1:0] aa_full;
	logic signed [css_pkg::PRODUCT_W-1:0] bb_full;
	logic signed [css_pkg::DOT_W:0] dot_wide;
	logic [css_pkg::SQ_W:0] sa_wide;
	logic [css_pkg::SQ_W:0] sb_wide;
	logic signed [css_pkg::DOT_W-1:0] dot_next;
	logic [css_pkg::SQ_W-1:0] sa_next;
	logic [css_pkg::SQ_W-1:0] sb_next;
	logic ovf_next;

	// stage one holds a final pair until the queue has room
	assign advance = !valid_s1 || !(last_s1 && q_full);
	assign full = !advance;

	// products of the incoming pair
	assign ab_full = css_pkg::PRODUCT_W'(elem_a) * css_pkg::PRODUCT_W'(elem_b);
	assign aa_full = css_pkg::PRODUCT_W'(elem_a) * css_pkg::PRODUCT_W'(elem_a);
	assign bb_full = css_pkg::PRODUCT_W'(elem_b) * css_pkg::PRODUCT_W'(elem_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			last_s1 <= last;
			ab_s1 <= ab_full;
			aa_s1 <= $unsigned(aa_full);
			bb_s1 <= $unsigned(bb_full);
		end
	end

	// saturating sums
	always_comb begin
		dot_wide = {dot_q[css_pkg::DOT_W-1], dot_q}
			+ {{(css_pkg::DOT_W+1-css_pkg::PRODUCT_W){ab_s1[css_pkg::PRODUCT_W-1]}}, ab_s1};
		sa_wide = {1'b0, sa_q} + {{(css_pkg::SQ_W+1-css_pkg::PRODUCT_W){1'b0}}, aa_s1};
		sb_wide = {1'b0, sb_q} + {{(css_pkg::SQ_W+1-css_pkg::PRODUCT_W){1'b0}}, bb_s1};
		ovf_next = ovf_q;
		dot_next = dot_wide[css_pkg::DOT_W-1:0];
		sa_next = sa_wide[css_pkg::SQ_W-1:0];
		sb_next = sb_wide[css_pkg::SQ_W-1:0];
		if (dot_wide[css_pkg::DOT_W] != dot_wide[css_pkg::DOT_W-1]) begin
			ovf_next = 1'b1;
			dot_next = dot_wide[css_pkg::DOT_W] ? css_pkg::DOT_MIN : css_pkg::DOT_MAX;
		end
		if (sa_wide[css_pkg::SQ_W]) begin
			ovf_next = 1'b1;
			sa_next = css_pkg::SQ_MAX;
		end
		if (sb_wide[css_pkg::SQ_W]) begin
			ovf_next = 1'b1;
			sb_next = css_pkg::SQ_MAX;
		end
	end

	// accumulators, cleared once a final pair is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			sa_q <= '0;
			sb_q <= '0;
			ovf_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				dot_q <= '0;
				sa_q <= '0;
				sb_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				dot_q <= dot_next;
				sa_q <= sa_next;
				sb_q <= sb_next;
				ovf_q <= ovf_next;
			end
		end
	end

	// job word for the back end
	assign job_push = valid_s1 && last_s1 && !q_full;
	assign job.dot = dot_next;
	assign job.sa = sa_next;
	assign job.sb = sb_next;
	assign job.ovf = ovf_next;

endmodule

`default_nettype wire

/* rtl/core/css_queue.sv */
// two-entry job queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module css_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire css_pkg::job_t wr_job,
	output logic full,
	input wire logic rd_en,
	output logic rd_valid,
	output css_pkg::job_t rd_job
);

	css_pkg::job_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q[1];
	assign rd_valid = count_q != 2'd0;
	assign rd_job = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({wr_en, rd_en})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/css_back.sv */
// back end: shift-add products, restoring divide, integer root, result register
`timescale 1ns / 1ps
`default_nettype none

module css_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	input wire css_pkg::job_t job,
	output logic job_pop,
	output logic signed [css_pkg::SIM_W-1:0] similarity,
	output logic zero_vector,
	output logic saturated,
	output logic empty,
	input wire logic pop
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_CHK  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_SQRT = 6'b010000,
		ST_FIN  = 6'b100000
	} back_state_t;

	back_state_t state_q;
	logic [css_pkg::CNT_W-1:0] cnt_q;

	// job operands
	logic neg_q;
	logic zero_q;
	logic ovf_q;
	logic [css_pkg::SQ_W-1:0] sa_q;
	logic [css_pkg::MAG_W-1:0] mag_q;
	logic [css_pkg::MAG_W-1:0] sb_sh_q;
	logic [css_pkg::MAG_W-1:0] mg_sh_q;

	// datapath registers
	logic [css_pkg::PROD_W-1:0] prod_q;
	logic [css_pkg::MAGSQ_W-1:0] magsq_q;
	logic [css_pkg::REM_W-1:0] rem_q;
	logic [css_pkg::REM_W-1:0] dv_q;
	logic [css_pkg::QUO_W-1:0] quo_q;
	logic [css_pkg::ROOT_W-1:0] root_q;
	logic [css_pkg::SREM_W-1:0] srem_q;

	// result register
	logic res_valid_q;
	logic signed [css_pkg::SIM_W-1:0] sim_q;
	logic res_zero_q;
	logic res_sat_q;

	logic [css_pkg::MAG_W-1:0] job_mag;
	logic div_sat;
	logic div_take;
	logic [css_pkg::SREM_W-1:0] srem_sh;
	logic [css_pkg::SREM_W-1:0] trial;
	logic sqrt_take;
	logic [css_pkg::ROOT_W:0] q_round;
	logic [css_pkg::SIM_W-1:0] q_clamp;
	logic signed [css_pkg::SIM_W-1:0] sim_next;
	logic res_write;

	assign job_pop = (state_q == ST_IDLE) && job_valid;
	assign job_mag = job.dot[css_pkg::DOT_W-1] ? $unsigned(-job.dot) : $unsigned(job.dot);

	// saturated quotient check: magsq * 2^30 >= prod * 2^32
	assign div_sat = magsq_q >= {prod_q, 2'b00};
	assign div_take = rem_q >= dv_q;

	// one root digit per step
	assign srem_sh = {srem_q[css_pkg::SREM_W-3:0], quo_q[css_pkg::QUO_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign sqrt_take = srem_sh >= trial;

	// round the root to the Q1.14 magnitude, clamp and apply the sign, or give zero for a zero vector
	always_comb begin
		q_round = ({1'b0, root_q} + {{css_pkg::ROOT_W{1'b0}}, 1'b1}) >> 1;
		if (q_round > {1'b0, $unsigned(css_pkg::ONE_Q14)}) begin
			q_clamp = $unsigned(css_pkg::ONE_Q14);
		end else begin
			q_clamp = q_round[css_pkg::SIM_W-1:0];
		end
		if (zero_q) begin
			sim_next = '0;
		end else if (neg_q) begin
			sim_next = -$signed(q_clamp);
		end else begin
			sim_next = $signed(q_clamp);
		end
	end

	assign res_write = (state_q == ST_FIN) && (!res_valid_q || pop);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (job_valid) begin
						if (job.sa == '0 || job.sb == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (cnt_q == css_pkg::CNT_W'(css_pkg::MUL_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_CHK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CHK: begin
					cnt_q <= '0;
					state_q <= div_sat ? ST_SQRT : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == css_pkg::CNT_W'(css_pkg::DIV_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == css_pkg::CNT_W'(css_pkg::SQRT_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (res_write) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q <= '0;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					neg_q <= job.dot[css_pkg::DOT_W-1];
					zero_q <= (job.sa == '0) || (job.sb == '0);
					ovf_q <= job.ovf;
					sa_q <= job.sa;
					mag_q <= job_mag;
					mg_sh_q <= job_mag;
					sb_sh_q <= {1'b0, job.sb};
					prod_q <= '0;
					magsq_q <= '0;
				end
			end
			ST_MUL: begin
				// msb-first shift-add, both products side by side
				prod_q <= {prod_q[css_pkg::PROD_W-2:0], 1'b0}
					+ (sb_sh_q[css_pkg::MAG_W-1]
						? {{(css_pkg::PROD_W-css_pkg::SQ_W){1'b0}}, sa_q}
						: {css_pkg::PROD_W{1'b0}});
				magsq_q <= {magsq_q[css_pkg::MAGSQ_W-2:0], 1'b0}
					+ (mg_sh_q[css_pkg::MAG_W-1]
						? {{(css_pkg::MAGSQ_W-css_pkg::MAG_W){1'b0}}, mag_q}
						: {css_pkg::MAGSQ_W{1'b0}});
				sb_sh_q <= {sb_sh_q[css_pkg::MAG_W-2:0], 1'b0};
				mg_sh_q <= {mg_sh_q[css_pkg::MAG_W-2:0], 1'b0};
			end
			ST_CHK: begin
				rem_q <= {magsq_q, 30'b0};
				dv_q <= {1'b0, prod_q, 31'b0};
				quo_q <= div_sat ? {css_pkg::QUO_W{1'b1}} : {css_pkg::QUO_W{1'b0}};
				root_q <= '0;
				srem_q <= '0;
			end
			ST_DIV: begin
				if (div_take) begin
					rem_q <= rem_q - dv_q;
				end
				quo_q <= {quo_q[css_pkg::QUO_W-2:0], div_take};
				dv_q <= dv_q >> 1;
			end
			ST_SQRT: begin
				srem_q <= sqrt_take ? srem_sh - trial : srem_sh;
				root_q <= {root_q[css_pkg::ROOT_W-2:0], sqrt_take};
				quo_q <= {quo_q[css_pkg::QUO_W-3:0], 2'b00};
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// result word held until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_write) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_write) begin
			sim_q <= sim_next;
			res_zero_q <= zero_q;
			res_sat_q <= ovf_q;
		end
	end

	assign similarity = sim_q;
	assign zero_vector = res_zero_q;
	assign saturated = res_sat_q;
	assign empty = !res_valid_q;

	// zero magnitude always gives a zero similarity
	a_zero_sim: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_zero_q |-> sim_q == '0)
		else $error("zero vector result with nonzero similarity");

	// similarity stays within minus one to one
	a_sim_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (sim_q <= css_pkg::ONE_Q14) && (sim_q >= -css_pkg::ONE_Q14))
		else $error("similarity out of range");

	// partial remainder below twice the shifted divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> {1'b0, rem_q} < {dv_q, 1'b0})
		else $error("divider remainder out of bounds");

	// waiting result word is neither lost nor changed
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !pop |=> res_valid_q && $stable(sim_q))
		else $error("result word dropped or changed while waiting");

endmodule

`default_nettype wire

/* rtl/core/cosine_similarity_stream_top.sv */
// The front takes one element pair a cycle unless a final pair waits for queue room.
// The back end works on one vector pair at a time: 38-step products, a 32-step divide and a
// 16-step root; the divide is skipped when the quotient saturates, and products, divide and
// root are all skipped when a vector is zero.
// A two-entry job queue lets the front run ahead; a final pair waits while it is full.
// Reset: arst_n is asynchronous, active low; it clears accumulators, queue and result word.
`timescale 1ns / 1ps
`default_nettype none

module cosine_similarity_stream_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic signed [css_pkg::ELEM_W-1:0] elem_a,
	input wire logic signed [css_pkg::ELEM_W-1:0] elem_b,
	input wire logic last,
	input wire logic push,
	output logic full,
	output logic signed [css_pkg::SIM_W-1:0] similarity,
	output logic zero_vector,
	output logic saturated,
	output logic empty,
	input wire logic pop
);

	css_pkg::job_t front_job;
	css_pkg::job_t back_job;
	logic job_push;
	logic q_full;
	logic job_valid;
	logic job_pop;

	// accumulate element pairs
	css_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.elem_a(elem_a),
		.elem_b(elem_b),
		.last(last),
		.push(push),
		.full(full),
		.job(front_job),
		.job_push(job_push),
		.q_full(q_full)
	);

	// finished sums waiting for the back end
	css_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(job_push),
		.wr_job(front_job),
		.full(q_full),
		.rd_en(job_pop),
		.rd_valid(job_valid),
		.rd_job(back_job)
	);

	// similarity from the sums
	css_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job(back_job),
		.job_pop(job_pop),
		.similarity(similarity),
		.zero_vector(zero_vector),
		.saturated(saturated),
		.empty(empty),
		.pop(pop)
	);

endmodule

`default_nettype wire

/* tb/sv/cosine_similarity_stream_checker.sv */
// scoreboard for the cosine similarity stream: running sums, expected scores and comparison
`timescale 1ns / 1ps
`default_nettype none

module cosine_similarity_stream_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic signed [css_pkg::ELEM_W-1:0] elem_a,
	input wire logic signed [css_pkg::ELEM_W-1:0] elem_b,
	input wire logic last,
	input wire logic push,
	input wire logic full,
	input wire logic signed [css_pkg::SIM_W-1:0] similarity,
	input wire logic zero_vector,
	input wire logic saturated,
	input wire logic empty,
	input wire logic pop,
	output int mismatches,
	output int scores_due
);

	// accumulator bounds in Q9.28 and one in Q1.14
	localparam longint DOT_CEIL = 64'sh0000_001F_FFFF_FFFF;
	localparam longint DOT_FLOOR = -64'sh0000_0020_0000_0000;
	localparam longint unsigned SQ_CEIL = 64'h0000_001F_FFFF_FFFF;
	localparam int unsigned UNIT_Q14 = 16384;

	typedef struct packed {
		logic signed [css_pkg::SIM_W-1:0] sim;
		logic zero;
		logic sat;
	} score_t;

	// scores predicted but not yet seen on the result side
	score_t scores_q[$];

	// running sums of the vector pair in progress
	longint dot_acc;
	longint unsigned sq_a;
	longint unsigned sq_b;
	bit clamped;
	int fails;

	// q14 magnitude rounded to nearest: largest q with (2q-1)^2*sa*sb <= (2^15*|dot|)^2
	function automatic logic signed [css_pkg::SIM_W-1:0] cosine_q14(input longint dot,
			input longint unsigned sa, input longint unsigned sb);
		longint unsigned mag;
		bit [127:0] bound;
		bit [127:0] odd;
		bit [127:0] lhs;
		int unsigned q;
		int unsigned trial;
		logic signed [css_pkg::SIM_W-1:0] r;
		if (dot < 0) begin
			mag = -dot;
		end else begin
			mag = dot;
		end
		bound = {64'd0, mag} << 15;
		bound = bound * bound;
		q = 0;
		for (int k = 14; k >= 0; k--) begin
			trial = q | (32'd1 << k);
			odd = 128'(2 * trial - 1);
			lhs = odd * odd * {64'd0, sa} * {64'd0, sb};
			if (lhs <= bound) begin
				q = trial;
			end
		end
		if (q > UNIT_Q14) begin
			q = UNIT_Q14;
		end
		r = q[15:0];
		if (dot < 0) begin
			r = -r;
		end
		return r;
	endfunction

	// fold one element pair into the sums; a closing pair yields a score
	task fold_pair(input logic signed [css_pkg::ELEM_W-1:0] a16,
			input logic signed [css_pkg::ELEM_W-1:0] b16, input logic fin);
		longint a;
		longint b;
		longint d;
		longint unsigned pa;
		longint unsigned pb;
		score_t s;
		a = longint'(a16);
		b = longint'(b16);
		d = dot_acc + a * b;
		pa = sq_a + 64'(a * a);
		pb = sq_b + 64'(b * b);
		if (d > DOT_CEIL) begin
			d = DOT_CEIL;
			clamped = 1'b1;
		end
		if (d < DOT_FLOOR) begin
			d = DOT_FLOOR;
			clamped = 1'b1;
		end
		if (pa > SQ_CEIL) begin
			pa = SQ_CEIL;
			clamped = 1'b1;
		end
		if (pb > SQ_CEIL) begin
			pb = SQ_CEIL;
			clamped = 1'b1;
		end
		dot_acc = d;
		sq_a = pa;
		sq_b = pb;
		if (fin) begin
			s.zero = (sq_a == 0) || (sq_b == 0);
			s.sim = s.zero ? '0 : cosine_q14(dot_acc, sq_a, sq_b);
			s.sat = clamped;
			scores_q.push_back(s);
			dot_acc = 0;
			sq_a = 0;
			sq_b = 0;
			clamped = 1'b0;
		end
	endtask

	// compare each popped word with the oldest score, then fold each pushed word
	always @(posedge clk or negedge arst_n) begin : watch
		score_t want;
		if (!arst_n) begin
			scores_q.delete();
			dot_acc = 0;
			sq_a = 0;
			sq_b = 0;
			clamped = 1'b0;
			fails = 0;
			mismatches <= 0;
			scores_due <= 0;
		end else begin
			if (pop && !empty) begin
				if (scores_q.size() == 0) begin
					$error("result word with no score due: similarity %0d", similarity);
					fails++;
				end else begin
					want = scores_q.pop_front();
					if (similarity !== want.sim) begin
						$error("similarity: expected %0d, actual %0d", want.sim, similarity);
						fails++;
					end
					if (zero_vector !== want.zero) begin
						$error("zero_vector: expected %0d, actual %0d", want.zero,
							zero_vector);
						fails++;
					end
					if (saturated !== want.sat) begin
						$error("saturated: expected %0d, actual %0d", want.sat, saturated);
						fails++;
					end
				end
			end
			if (push && !full) begin
				fold_pair(elem_a, elem_b, last);
			end
			mismatches <= fails;
			scores_due <= scores_q.size();
		end
	end

endmodule

`default_nettype wire

/* tb/sv/cosine_similarity_stream_top_tb.sv */
// testbench top for the cosine similarity stream: stimulus, result draining and verdict
`timescale 1ns / 1ps
`default_nettype none

module cosine_similarity_stream_top_tb;

	localparam int RANDOM_PAIRS = 650;
	localparam int HOLD_CYCLES = 1000;
	localparam int HOLD_AFTER = 25;
	localparam int DRAIN_CYCLES = 120;
	localparam int IDLE_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic signed [css_pkg::ELEM_W-1:0] elem_a;
	logic signed [css_pkg::ELEM_W-1:0] elem_b;
	logic last;
	logic push;
	logic full;
	logic signed [css_pkg::SIM_W-1:0] similarity;
	logic zero_vector;
	logic saturated;
	logic empty;
	logic pop;

	int mismatches;
	int scores_due;
	int pairs_sent;
	int scores_taken;
	int idle_cycles;
	bit sender_burst;

	cosine_similarity_stream_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.elem_a(elem_a),
		.elem_b(elem_b),
		.last(last),
		.push(push),
		.full(full),
		.similarity(similarity),
		.zero_vector(zero_vector),
		.saturated(saturated),
		.empty(empty),
		.pop(pop)
	);

	cosine_similarity_stream_checker score_watch (
		.clk(clk),
		.arst_n(arst_n),
		.elem_a(elem_a),
		.elem_b(elem_b),
		.last(last),
		.push(push),
		.full(full),
		.similarity(similarity),
		.zero_vector(zero_vector),
		.saturated(saturated),
		.empty(empty),
		.pop(pop),
		.mismatches(mismatches),
		.scores_due(scores_due)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// offer one element pair after a random gap (none in a burst), hold it until taken
	task send_pair(input logic signed [css_pkg::ELEM_W-1:0] a,
			input logic signed [css_pkg::ELEM_W-1:0] b, input logic fin);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem_a <= a;
		elem_b <= b;
		last <= fin;
		push <= 1'b1;
		do @(posedge clk); while (full);
		pairs_sent++;
	endtask

	// element value in one of several styles
	function automatic logic signed [css_pkg::ELEM_W-1:0] pick_elem(input int style);
		logic signed [css_pkg::ELEM_W-1:0] v;
		case (style)
			0: begin
				v = css_pkg::ELEM_W'($urandom);
			end
			1: begin
				v = css_pkg::ELEM_W'($signed($urandom_range(0, 64)) - 32);
			end
			2: begin
				case ($urandom_range(0, 4))
					0: v = 16'sh8000;
					1: v = 16'sh7FFF;
					2: v = -16'sd1;
					3: v = 16'sd1;
					default: v = '0;
				endcase
			end
			default: begin
				v = '0;
			end
		endcase
		return v;
	endfunction

	// short vector pair of a random kind
	task send_short_vectors();
		int len;
		int kind;
		int style;
		logic signed [css_pkg::ELEM_W-1:0] a;
		logic signed [css_pkg::ELEM_W-1:0] b;
		len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 10);
		kind = $urandom_range(0, 9);
		for (int i = 0; i < len; i++) begin
			style = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			a = pick_elem(style);
			b = pick_elem(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			case (kind)
				0: a = '0;
				1: b = '0;
				2: b = a;
				3: b = -a;
				default: ;
			endcase
			send_pair(a, b, i == len - 1);
		end
	endtask

	// sums of squares overflow exactly on the closing pair
	task send_flood_aligned();
		for (int i = 0; i < 128; i++) begin
			send_pair(16'sh8000, 16'sh8000, i == 127);
		end
	endtask

	// dot product runs off the negative end, result magnitude clamps to one
	task send_flood_opposed();
		int len;
		len = $urandom_range(130, 150);
		for (int i = 0; i < len; i++) begin
			send_pair(16'sh8000 + css_pkg::ELEM_W'($urandom_range(0, 7)),
				16'sh7FFF - css_pkg::ELEM_W'($urandom_range(0, 7)), i == len - 1);
		end
	endtask

	// stimulus and verdict
	initial begin : stimulus
		int vec;
		arst_n <= 1'b0;
		push <= 1'b0;
		elem_a <= '0;
		elem_b <= '0;
		last <= 1'b0;
		pairs_sent = 0;
		sender_burst = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: unit and opposite vectors, field extremes, zero magnitude, orthogonality
		send_pair(16'sd16384, 16'sd16384, 1'b1);
		send_pair(16'sd16384, -16'sd16384, 1'b1);
		send_pair(16'sh7FFF, 16'sh8000, 1'b1);
		send_pair(16'sh8000, 16'sh8000, 1'b1);
		send_pair(16'sd0, 16'sd5, 1'b1);
		send_pair(-16'sd7, 16'sd0, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(16'sd1, 16'sd0, 1'b0);
		send_pair(16'sd0, 16'sd1, 1'b1);
		send_pair(16'sd3, 16'sd4, 1'b0);
		send_pair(16'sd4, -16'sd3, 1'b1);
		sender_burst = 1'b1;
		send_pair(16'sd1, 16'sd1, 1'b0);
		send_pair(-16'sd1, -16'sd1, 1'b0);
		send_pair(16'sd1, -16'sd1, 1'b1);
		send_pair(16'sd2, 16'sd3, 1'b0);
		send_pair(16'sd3, 16'sd2, 1'b1);
		sender_burst = 1'b0;
		send_pair(16'sd12345, -16'sd23456, 1'b0);
		send_pair(16'sh8000, 16'sh7FFF, 1'b0);
		send_pair(-16'sd1, 16'sd1, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b0);
		send_pair(16'sd0, 16'sd0, 1'b1);

		// random vector pairs, with two long ones that saturate
		pairs_sent = 0;
		vec = 0;
		while (pairs_sent < RANDOM_PAIRS) begin
			sender_burst = ($urandom_range(0, 7) == 0);
			if (vec == 3) begin
				send_flood_aligned();
			end else if (vec == 30) begin
				send_flood_opposed();
			end else begin
				send_short_vectors();
			end
			vec++;
		end
		push <= 1'b0;

		// wait for every score, then a latency's worth more for strays
		do @(posedge clk); while (scores_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("cosine_similarity_stream_top: match");
		end else begin
			$display("cosine_similarity_stream_top: mismatch");
		end
		$finish;
	end

	// result side: random gaps, some gap-free runs, one long hold-off
	initial begin : receiver
		int gap;
		bit held;
		pop <= 1'b0;
		scores_taken = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && scores_taken == HOLD_AFTER) begin
				held = 1'b1;
				gap = HOLD_CYCLES;
			end else if ((scores_taken % 12) < 3) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 19);
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			scores_taken++;
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("cosine_similarity_stream_top: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

`default_nettype wire
